>>> hw/rtl/bba_pkg.sv
// Shared constants, types and helper functions for the bitmap block allocator.
// Used by bitmap_block_allocator; depends on nothing else.
package bba_pkg;

  localparam int MAP_BITS      = 512;
  localparam int NUM_MAPS      = 64;
  localparam int WORD_BITS     = 64;
  localparam int WORDS_PER_MAP = MAP_BITS / WORD_BITS;
  localparam int TOTAL_WORDS   = NUM_MAPS * WORDS_PER_MAP;

  localparam int ADDR_W = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
  localparam int WIDX_W = (WORDS_PER_MAP > 1) ? $clog2(WORDS_PER_MAP) : 1;
  localparam int BIT_W  = $clog2(WORD_BITS);

  // Field widths of the item and result ports and of the configuration register.
  localparam int BLK_W  = 15;
  localparam int HINT_W = 7;
  localparam int CFG_W  = 7;

  // Configuration port.
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_MAPS_IN_USE = 1'b0;
  localparam logic [CFG_W-1:0]     MAPS_IN_USE_RST = 7'd64;

  // Operation and status codes.
  localparam logic OP_ALLOC    = 1'b0;
  localparam logic OP_FREE     = 1'b1;
  localparam logic ST_DONE     = 1'b0;
  localparam logic ST_NO_SPACE = 1'b1;

  typedef logic [WORD_BITS-1:0] word_t;

  // Index of the single set bit of a one-hot word.
  function automatic logic [BIT_W-1:0] onehot_index(input word_t onehot);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (onehot[i]) begin
        idx = idx | BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> hw/rtl/bitmap_block_allocator.sv
// Bitmap free-block allocator: usage bit memory, hint register and sequencer.
// Depends on bba_pkg for constants, types and codes.
// An allocate checks the hint against the limit, scans the hint map and sets one bit, stepping
// the hint over every full map; a failed allocate at the limit stops after the check; a free
// reads and writes one word. Items do not overlap; the map scan reads one word per cycle.
// Reset: a clearing pass zeroes all 512 words of the usage memory; items are stalled until it ends.
module bitmap_block_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  // Item input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_operation,
  input  logic [bba_pkg::BLK_W-1:0]   in_block_number,
  // Result output
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bba_pkg::BLK_W-1:0]   out_granted_block,
  output logic                        out_status,
  output logic [bba_pkg::HINT_W-1:0]  out_hint_map,
  output logic                        out_hint_changed,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bba_pkg::PADDR_W-1:0] paddr,
  input  logic [bba_pkg::PDATA_W-1:0] pwdata,
  output logic [bba_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_CHECK   = 4'd2;
  localparam logic [3:0] S_SCAN    = 4'd3;
  localparam logic [3:0] S_SET     = 4'd4;
  localparam logic [3:0] S_FREE_RD = 4'd5;
  localparam logic [3:0] S_FREE_WR = 4'd6;
  localparam logic [3:0] S_DONE    = 4'd7;

  logic [3:0]                    state_r, state_nxt;
  logic [bba_pkg::HINT_W-1:0]    hint_r, hint_nxt;
  logic [bba_pkg::HINT_W-1:0]    old_hint_r, old_hint_nxt;
  logic                          op_r, op_nxt;
  logic [bba_pkg::BLK_W-1:0]     blk_r, blk_nxt;
  logic [bba_pkg::WIDX_W:0]      issue_cnt_r, issue_cnt_nxt;
  logic                          rd_vld_r, rd_vld_nxt;
  logic [bba_pkg::WIDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                          found_r, found_nxt;
  logic                          other_r, other_nxt;
  logic [bba_pkg::WIDX_W-1:0]    fw_idx_r, fw_idx_nxt;
  bba_pkg::word_t                fw_data_r, fw_data_nxt;
  logic [bba_pkg::BLK_W-1:0]     res_granted_r, res_granted_nxt;
  logic                          res_status_r, res_status_nxt;
  logic [bba_pkg::ADDR_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [bba_pkg::CFG_W-1:0]     maps_in_use_r;

  logic                          out_valid_r, out_valid_nxt;
  logic [bba_pkg::BLK_W-1:0]     out_granted_r, out_granted_nxt;
  logic                          out_status_r, out_status_nxt;
  logic [bba_pkg::HINT_W-1:0]    out_hint_r, out_hint_nxt;
  logic                          out_changed_r, out_changed_nxt;

  // Usage memory: one bit per block, set means in use.
  bba_pkg::word_t                usage_mem [bba_pkg::TOTAL_WORDS];
  bba_pkg::word_t                rd_data_r;
  logic                          mem_we;
  logic [bba_pkg::ADDR_W-1:0]    mem_waddr;
  logic [bba_pkg::ADDR_W-1:0]    mem_raddr;
  bba_pkg::word_t                mem_wdata;

  logic                          in_acc;
  logic                          cfg_wr;
  logic [bba_pkg::HINT_W-1:0]    limit;
  logic [bba_pkg::HINT_W-1:0]    hint_inc;
  logic [bba_pkg::ADDR_W-1:0]    scan_addr;
  logic                          word_open;
  logic                          last_word;
  bba_pkg::word_t                set_onehot;
  bba_pkg::word_t                set_word;
  logic [bba_pkg::BIT_W-1:0]     set_bit;
  logic                          full_after;
  logic [bba_pkg::BLK_W-1:0]     free_map;
  logic [bba_pkg::BIT_W-1:0]     free_bit;
  logic [bba_pkg::ADDR_W-1:0]    free_addr;
  logic                          free_in_range;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = (paddr[2 +: bba_pkg::REG_IDX_W] == bba_pkg::REG_MAPS_IN_USE) ?
                    bba_pkg::PDATA_W'(maps_in_use_r) : '0;

  assign limit    = (32'(maps_in_use_r) < bba_pkg::NUM_MAPS) ? maps_in_use_r :
                    bba_pkg::HINT_W'(bba_pkg::NUM_MAPS);
  assign hint_inc = hint_r + 1'b1;

  assign scan_addr = bba_pkg::ADDR_W'(32'(hint_r) * bba_pkg::WORDS_PER_MAP +
                                      32'(issue_cnt_r[bba_pkg::WIDX_W-1:0]));
  assign word_open = (rd_data_r != '1);
  assign last_word = rd_vld_r && (rd_idx_r == bba_pkg::WIDX_W'(bba_pkg::WORDS_PER_MAP - 1));

  // Lowest clear bit of the chosen word, isolated by one add.
  assign set_onehot = ~fw_data_r & (fw_data_r + 1'b1);
  assign set_word   = fw_data_r | set_onehot;
  assign set_bit    = bba_pkg::onehot_index(set_onehot);
  assign full_after = !other_r && (set_word == '1);

  assign free_map      = bba_pkg::BLK_W'(32'(blk_r) / bba_pkg::MAP_BITS);
  assign free_bit      = bba_pkg::BIT_W'((32'(blk_r) % bba_pkg::MAP_BITS) % bba_pkg::WORD_BITS);
  assign free_addr     = bba_pkg::ADDR_W'(32'(free_map) * bba_pkg::WORDS_PER_MAP +
                         (32'(blk_r) % bba_pkg::MAP_BITS) / bba_pkg::WORD_BITS);
  assign free_in_range = (32'(free_map) < bba_pkg::NUM_MAPS);

  assign mem_raddr = (state_r == S_FREE_RD) ? free_addr : scan_addr;

  always_comb begin
    state_nxt       = state_r;
    hint_nxt        = hint_r;
    old_hint_nxt    = old_hint_r;
    op_nxt          = op_r;
    blk_nxt         = blk_r;
    issue_cnt_nxt   = issue_cnt_r;
    rd_vld_nxt      = 1'b0;
    rd_idx_nxt      = rd_idx_r;
    found_nxt       = found_r;
    other_nxt       = other_r;
    fw_idx_nxt      = fw_idx_r;
    fw_data_nxt     = fw_data_r;
    res_granted_nxt = res_granted_r;
    res_status_nxt  = res_status_r;
    clr_cnt_nxt     = clr_cnt_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_granted_nxt = out_granted_r;
    out_status_nxt  = out_status_r;
    out_hint_nxt    = out_hint_r;
    out_changed_nxt = out_changed_r;
    mem_we          = 1'b0;
    mem_waddr       = clr_cnt_r;
    mem_wdata       = '0;

    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == bba_pkg::ADDR_W'(bba_pkg::TOTAL_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          op_nxt          = in_operation;
          blk_nxt         = in_block_number;
          old_hint_nxt    = hint_r;
          res_granted_nxt = '0;
          res_status_nxt  = bba_pkg::ST_DONE;
          state_nxt       = (in_operation == bba_pkg::OP_FREE) ? S_FREE_RD : S_CHECK;
        end
      end
      S_CHECK: begin
        issue_cnt_nxt = '0;
        found_nxt     = 1'b0;
        other_nxt     = 1'b0;
        if (hint_r >= limit) begin
          res_status_nxt = bba_pkg::ST_NO_SPACE;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // Words are read one per cycle; each is examined the cycle after its read.
        if (32'(issue_cnt_r) < bba_pkg::WORDS_PER_MAP) begin
          issue_cnt_nxt = issue_cnt_r + 1'b1;
          rd_vld_nxt    = 1'b1;
          rd_idx_nxt    = issue_cnt_r[bba_pkg::WIDX_W-1:0];
        end
        if (rd_vld_r && word_open) begin
          if (!found_r) begin
            found_nxt   = 1'b1;
            fw_idx_nxt  = rd_idx_r;
            fw_data_nxt = rd_data_r;
          end else begin
            other_nxt = 1'b1;
          end
        end
        if (last_word) begin
          if (found_r || word_open) begin
            state_nxt = S_SET;
          end else begin
            // The whole map is full: step the hint to the next map.
            hint_nxt = hint_inc;
            if (hint_inc >= limit) begin
              res_status_nxt = bba_pkg::ST_NO_SPACE;
              state_nxt      = S_DONE;
            end else begin
              issue_cnt_nxt = '0;
            end
          end
        end
      end
      S_SET: begin
        mem_we          = 1'b1;
        mem_waddr       = bba_pkg::ADDR_W'(32'(hint_r) * bba_pkg::WORDS_PER_MAP + 32'(fw_idx_r));
        mem_wdata       = set_word;
        res_granted_nxt = bba_pkg::BLK_W'(32'(hint_r) * bba_pkg::MAP_BITS +
                                          32'(fw_idx_r) * bba_pkg::WORD_BITS + 32'(set_bit));
        if (full_after) begin
          hint_nxt = hint_inc;
        end
        state_nxt = S_DONE;
      end
      S_FREE_RD: begin
        state_nxt = S_FREE_WR;
      end
      S_FREE_WR: begin
        if (free_in_range) begin
          mem_we    = 1'b1;
          mem_waddr = free_addr;
          mem_wdata = rd_data_r & ~(bba_pkg::word_t'(1) << free_bit);
          if (32'(free_map) < 32'(hint_r)) begin
            hint_nxt = bba_pkg::HINT_W'(free_map);
          end
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_granted_nxt = res_granted_r;
          out_status_nxt  = res_status_r;
          out_hint_nxt    = hint_r;
          out_changed_nxt = (hint_r != old_hint_r);
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      hint_r        <= '0;
      clr_cnt_r     <= '0;
      rd_vld_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      maps_in_use_r <= bba_pkg::MAPS_IN_USE_RST;
    end else begin
      state_r     <= state_nxt;
      hint_r      <= hint_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr && paddr[2 +: bba_pkg::REG_IDX_W] == bba_pkg::REG_MAPS_IN_USE) begin
        maps_in_use_r <= pwdata[bba_pkg::CFG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    old_hint_r    <= old_hint_nxt;
    op_r          <= op_nxt;
    blk_r         <= blk_nxt;
    issue_cnt_r   <= issue_cnt_nxt;
    rd_idx_r      <= rd_idx_nxt;
    found_r       <= found_nxt;
    other_r       <= other_nxt;
    fw_idx_r      <= fw_idx_nxt;
    fw_data_r     <= fw_data_nxt;
    res_granted_r <= res_granted_nxt;
    res_status_r  <= res_status_nxt;
    out_granted_r <= out_granted_nxt;
    out_status_r  <= out_status_nxt;
    out_hint_r    <= out_hint_nxt;
    out_changed_r <= out_changed_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      usage_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= usage_mem[mem_raddr];
  end

  assign out_valid         = out_valid_r;
  assign out_granted_block = out_granted_r;
  assign out_status        = out_status_r;
  assign out_hint_map      = out_hint_r;
  assign out_hint_changed  = out_changed_r;

  // A grant sets exactly one bit that was clear.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SET |-> $countones(set_word) == $countones(fw_data_r) + 1)
    else $error("allocation did not set exactly one new bit");

  // A successful allocate grants a block in the hint map or the map just below the new hint.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && op_r == bba_pkg::OP_ALLOC && res_status_r == bba_pkg::ST_DONE |->
      (32'(res_granted_r) / bba_pkg::MAP_BITS == 32'(hint_r)) ||
      (32'(res_granted_r) / bba_pkg::MAP_BITS + 1 == 32'(hint_r)))
    else $error("granted block lies outside the hint map");

  // No space is only reported once the hint stands at or past the limit.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && res_status_r == bba_pkg::ST_NO_SPACE |-> hint_r >= limit)
    else $error("no-space status with hint below limit");

  // The hint never runs past the number of maps.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_CLEAR |=> 32'(hint_r) <= bba_pkg::NUM_MAPS)
    else $error("hint beyond the last map");

endmodule
